// ===== design/smcsr_pkg.sv =====
// Package for the compressed-row sparse matrix store.
// Holds register indexes, status codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
package smcsr_pkg;

  typedef logic [1:0] status_t;
  typedef logic [1:0] reg_idx_t;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam reg_idx_t REG_DEFAULT = 2'd0;
  localparam reg_idx_t REG_ROWS    = 2'd1;
  localparam reg_idx_t REG_COLS    = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RS_A  = 11'b00000000010,
    S_RS_B  = 11'b00000000100,
    S_SCAN  = 11'b00000001000,
    S_CHK   = 11'b00000010000,
    S_DEC   = 11'b00000100000,
    S_SHIFT = 11'b00001000000,
    S_INS   = 11'b00010000000,
    S_PTR   = 11'b00100000000,
    S_DONE  = 11'b01000000000,
    S_SPARE = 11'b10000000000
  } state_e;

endpackage

// ===== design/sparse_matrix_csr_store_core.sv =====
// A bad coordinate goes straight to the result; otherwise both row pointers are read, the row's terms
// scanned by column, and a remove or insert shifts the later terms, then updates the row pointers.
// One request at a time: busy holds through the strobe; next accept in the cycle after it.
// Reset clears the registers, the term count and the row pointers (all one).
// Term storage is undefined until written; results cannot be stalled.
`timescale 1ns / 1ps
module sparse_matrix_csr_store_core #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_TERMS  = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic                   mode_i,
  input  logic [6:0]             row_i,
  input  logic [6:0]             col_i,
  input  logic signed [31:0]     value_i,
  output logic                   result_valid_o,
  output logic signed [31:0]     read_value_o,
  output logic [8:0]             stored_terms_o,
  output smcsr_pkg::status_t     status_o
);
  import smcsr_pkg::*;

  localparam int TW  = $clog2(MAX_TERMS + 1);
  localparam int AW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int RAW = $clog2(MAX_ROWS + 1);

  function automatic logic [VALUE_BITS-1:0] from32(input logic [31:0] x);
    logic signed [63:0] e;
    e = 64'(signed'(x));
    return e[VALUE_BITS-1:0];
  endfunction

  function automatic logic [31:0] to32(input logic [VALUE_BITS-1:0] x);
    logic signed [63:0] e;
    e = 64'(signed'(x));
    return e[31:0];
  endfunction

  state_e state_q, state_d;

  logic [VALUE_BITS-1:0] def_q;
  logic [6:0]            rows_q, cols_q;

  logic                  mode_q;
  logic [6:0]            r_q, c_q;
  logic [VALUE_BITS-1:0] v_q, res_q, res_d;
  status_t               st_q, st_d;

  logic [TW-1:0]  tc_q, tc_d;
  logic [TW-1:0]  a_q, a_d, lo_d, hi_q, hi_d, i_q, i_d, pos_q, pos_d;
  logic           found_q, found_d, ins_q, ins_d;
  logic [AW-1:0]  wa_q, wa_d;
  logic           pend_q, pend_d;
  logic [RAW-1:0] k_q, k_d, kwa_q, kwa_d;
  logic           kmore_q, kmore_d;

  logic [TW-1:0]         rs_mem [MAX_ROWS+1];
  logic [MAX_ROWS:0]     rs_vld_q;
  logic [TW-1:0]         rs_rdata_q, rs_rd, rs_wdata;
  logic                  rs_vrd_q, rs_we;
  logic [RAW-1:0]        rs_raddr, rs_waddr;

  logic [6:0]            tcol_mem [MAX_TERMS];
  logic [VALUE_BITS-1:0] tval_mem [MAX_TERMS];
  logic [6:0]            tcol_rd_q, tm_wcol;
  logic [VALUE_BITS-1:0] tval_rd_q, tm_wval;
  logic                  tm_we;
  logic [AW-1:0]         tm_raddr, tm_waddr;

  logic          bad_coord, cfg_we;
  logic [TW-1:0] sa, sb, sb2;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_DEFAULT: prdata = to32(def_q);
      REG_ROWS:    prdata = {25'd0, rows_q};
      REG_COLS:    prdata = {25'd0, cols_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q  <= '0;
      rows_q <= '0;
      cols_q <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_DEFAULT: def_q  <= from32(pwdata);
        REG_ROWS:    rows_q <= pwdata[6:0];
        REG_COLS:    cols_q <= pwdata[6:0];
        default:     ;
      endcase
    end
  end

  assign bad_coord = (row_i == 7'd0) || (row_i > rows_q) || (int'(row_i) > MAX_ROWS) ||
                     (col_i == 7'd0) || (col_i > cols_q) || (int'(col_i) > MAX_COLS);

  assign rs_rd = rs_vrd_q ? rs_rdata_q : TW'(1);
  assign sa    = (a_q == '0) ? '0 : a_q - 1'b1;
  assign sb    = (rs_rd == '0) ? '0 : rs_rd - 1'b1;
  assign sb2   = (sb > tc_q) ? tc_q : sb;

  always_ff @(posedge clk_i) begin
    rs_rdata_q <= rs_mem[rs_raddr];
    if (rs_we) rs_mem[rs_waddr] <= rs_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_vld_q <= '0;
      rs_vrd_q <= 1'b0;
    end else begin
      rs_vrd_q <= rs_vld_q[rs_raddr];
      if (rs_we) rs_vld_q[rs_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    tcol_rd_q <= tcol_mem[tm_raddr];
    tval_rd_q <= tval_mem[tm_raddr];
    if (tm_we) begin
      tcol_mem[tm_waddr] <= tm_wcol;
      tval_mem[tm_waddr] <= tm_wval;
    end
  end

  always_comb begin
    state_d  = state_q;
    res_d    = res_q;
    st_d     = st_q;
    tc_d     = tc_q;
    a_d      = a_q;
    lo_d     = '0;
    hi_d     = hi_q;
    i_d      = i_q;
    pos_d    = pos_q;
    found_d  = found_q;
    ins_d    = ins_q;
    wa_d     = wa_q;
    pend_d   = pend_q;
    k_d      = k_q;
    kwa_d    = kwa_q;
    kmore_d  = kmore_q;
    rs_raddr = RAW'(row_i - 7'd1);
    rs_we    = 1'b0;
    rs_waddr = kwa_q;
    rs_wdata = ins_q ? rs_rd + 1'b1 : ((rs_rd > TW'(1)) ? rs_rd - 1'b1 : rs_rd);
    tm_raddr = AW'(i_q);
    tm_we    = 1'b0;
    tm_waddr = wa_q;
    tm_wcol  = tcol_rd_q;
    tm_wval  = tval_rd_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          res_d = def_q;
          st_d  = ST_DONE;
          if (bad_coord) begin
            st_d    = ST_RANGE;
            state_d = S_DONE;
          end else begin
            state_d = S_RS_A;
          end
        end
      end
      S_RS_A: begin
        a_d      = rs_rd;
        rs_raddr = RAW'(r_q);
        state_d  = S_RS_B;
      end
      S_RS_B: begin
        lo_d    = (sa > sb2) ? sb2 : sa;
        hi_d    = sb2;
        i_d     = lo_d;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (i_q == hi_q) begin
          found_d = 1'b0;
          pos_d   = hi_q;
          state_d = S_DEC;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (tcol_rd_q >= c_q) begin
          found_d = (tcol_rd_q == c_q);
          pos_d   = i_q;
          state_d = S_DEC;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_DEC: begin
        state_d = S_DONE;
        pend_d  = 1'b0;
        if (!mode_q) begin
          if (found_q) res_d = tval_rd_q;
        end else if (found_q) begin
          if (v_q != def_q) begin
            tm_we    = 1'b1;
            tm_waddr = AW'(pos_q);
            tm_wcol  = c_q;
            tm_wval  = v_q;
            res_d    = v_q;
          end else begin
            ins_d   = 1'b0;
            i_d     = pos_q;
            state_d = S_SHIFT;
          end
        end else if (v_q != def_q) begin
          if (tc_q >= TW'(MAX_TERMS)) begin
            st_d = ST_FULL;
          end else begin
            ins_d   = 1'b1;
            i_d     = tc_q;
            res_d   = v_q;
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        tm_we = pend_q;
        if (ins_q && (i_q > pos_q)) begin
          tm_raddr = AW'(i_q - 1'b1);
          wa_d     = AW'(i_q);
          i_d      = i_q - 1'b1;
          pend_d   = 1'b1;
        end else if (!ins_q && ((i_q + 1'b1) < tc_q)) begin
          tm_raddr = AW'(i_q + 1'b1);
          wa_d     = AW'(i_q);
          i_d      = i_q + 1'b1;
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            k_d     = RAW'(r_q);
            kmore_d = 1'b1;
            state_d = ins_q ? S_INS : S_PTR;
          end
        end
      end
      S_INS: begin
        tm_we    = 1'b1;
        tm_waddr = AW'(pos_q);
        tm_wcol  = c_q;
        tm_wval  = v_q;
        state_d  = S_PTR;
      end
      S_PTR: begin
        rs_we    = pend_q;
        rs_raddr = k_q;
        if (kmore_q) begin
          kwa_d  = k_q;
          pend_d = 1'b1;
          if (k_q == RAW'(MAX_ROWS)) kmore_d = 1'b0;
          else k_d = k_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            tc_d    = ins_q ? tc_q + 1'b1 : tc_q - 1'b1;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tc_q    <= '0;
      pend_q  <= 1'b0;
      kmore_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tc_q    <= tc_d;
      pend_q  <= pend_d;
      kmore_q <= kmore_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      mode_q <= mode_i;
      r_q    <= row_i;
      c_q    <= col_i;
      v_q    <= from32(value_i);
    end
    res_q   <= res_d;
    st_q    <= st_d;
    a_q     <= a_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    ins_q   <= ins_d;
    wa_q    <= wa_d;
    k_q     <= k_d;
    kwa_q   <= kwa_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);
  assign read_value_o   = to32(res_q);
  assign stored_terms_o = 9'(tc_q);
  assign status_o       = st_q;

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy)
    else $error("result strobe not followed by idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tc_q <= TW'(MAX_TERMS))
    else $error("term count above capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_FULL) |-> (tc_q == TW'(MAX_TERMS)))
    else $error("store full reported below capacity");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(tc_q) |-> $past(state_q == S_PTR))
    else $error("term count changed outside pointer pass");

endmodule

// ===== tb/sparse_matrix_csr_store_core_test.sv =====
// Self-checking testbench for sparse_matrix_csr_store_core: directed table, then random phases.
// Each result is checked against the table's expected outcome or a compressed-row predictor kept alongside the block.
// Depends on smcsr_pkg and the design top level.
`timescale 1ns / 1ps
module sparse_matrix_csr_store_core_test;
  import smcsr_pkg::*;

  typedef struct packed {
    logic signed [31:0] val;
    logic [8:0]         terms;
    status_t            stat;
  } outcome_t;

  typedef struct packed {
    logic               mode;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [31:0] value;
    logic               typed;
    outcome_t           outcome;
  } vector_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic mode_i = 1'b0;
  logic [6:0] row_i = '0, col_i = '0;
  logic signed [31:0] value_i = '0;
  logic result_valid_o;
  logic signed [31:0] read_value_o;
  logic [8:0] stored_terms_o;
  status_t status_o;

  sparse_matrix_csr_store_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("sparse_matrix_csr_store_core verification failed");
    $finish;
  end

  // predictor state
  logic [8:0]         row_start [0:64];
  logic [6:0]         term_col  [0:255];
  logic signed [31:0] term_val  [0:255];
  logic [8:0]         term_total;
  logic signed [31:0] dflt;
  logic [6:0]         n_rows, n_cols;

  outcome_t pending_results[$];
  bit       failed = 1'b0;

  function automatic outcome_t apply_request(logic m, logic [6:0] r, logic [6:0] c,
                                             logic signed [31:0] v);
    outcome_t res;
    int ri, ci, lo, hi, pos, i, k, cnt;
    bit found;
    ri = r;
    ci = c;
    cnt = term_total;
    res.val = dflt;
    res.stat = ST_DONE;
    found = 1'b0;
    if (ri == 0 || ri > n_rows || ri > 64 || ci == 0 || ci > n_cols || ci > 64) begin
      res.stat = ST_RANGE;
    end else begin
      lo = (row_start[ri-1] != 0) ? row_start[ri-1] - 1 : 0;
      hi = (row_start[ri] != 0) ? row_start[ri] - 1 : 0;
      if (hi > cnt) hi = cnt;
      if (lo > hi) lo = hi;
      pos = hi;
      for (i = lo; i < hi; i++)
        if (!found && term_col[i] == c) begin
          found = 1'b1;
          pos = i;
        end
      if (!m) begin
        if (found) res.val = term_val[pos];
      end else if (found) begin
        if (v != dflt) begin
          term_val[pos] = v;
          res.val = v;
        end else begin
          for (i = pos; i + 1 < cnt && i + 1 < 256; i++) begin
            term_val[i] = term_val[i+1];
            term_col[i] = term_col[i+1];
          end
          for (k = ri; k <= 64; k++)
            if (row_start[k] > 1) row_start[k] = row_start[k] - 9'd1;
          term_total = term_total - 9'd1;
        end
      end else if (v != dflt) begin
        if (cnt >= 256) begin
          res.stat = ST_FULL;
        end else begin
          pos = lo;
          while (pos < hi && term_col[pos] < c) pos++;
          for (i = cnt; i > pos; i--) begin
            term_val[i] = term_val[i-1];
            term_col[i] = term_col[i-1];
          end
          term_val[pos] = v;
          term_col[pos] = c;
          for (k = ri; k <= 64; k++) row_start[k] = row_start[k] + 9'd1;
          term_total = term_total + 9'd1;
          res.val = v;
        end
      end
    end
    res.terms = term_total;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result read_value=%0d", read_value_o);
        failed = 1'b1;
      end else begin
        outcome_t e;
        e = pending_results.pop_front();
        if (read_value_o !== e.val) begin
          $error("read_value expected %0d got %0d", e.val, read_value_o);
          failed = 1'b1;
        end
        if (stored_terms_o !== e.terms) begin
          $error("stored_terms expected %0d got %0d", e.terms, stored_terms_o);
          failed = 1'b1;
        end
        if (status_o !== e.stat) begin
          $error("status expected %0d got %0d", e.stat, status_o);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic send_request(vector_t vec, int gap);
    outcome_t predicted;
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    mode_i = vec.mode;
    row_i = vec.row;
    col_i = vec.col;
    value_i = vec.value;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predicted = apply_request(vec.mode, vec.row, vec.col, vec.value);
    pending_results.push_back(vec.typed ? vec.outcome : predicted);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_DEFAULT: dflt = data;
      REG_ROWS:    n_rows = data[6:0];
      default:     n_cols = data[6:0];
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_shape(logic [31:0] d, logic [6:0] r, logic [6:0] c);
    write_reg(REG_DEFAULT, d);
    write_reg(REG_ROWS, {25'd0, r});
    write_reg(REG_COLS, {25'd0, c});
  endtask

  function automatic vector_t vec(logic m, int r, int c, logic signed [31:0] v, logic t,
                                  logic signed [31:0] ev, int et, status_t es);
    vector_t x;
    x.mode = m;
    x.row = 7'(r);
    x.col = 7'(c);
    x.value = v;
    x.typed = t;
    x.outcome.val = ev;
    x.outcome.terms = 9'(et);
    x.outcome.stat = es;
    return x;
  endfunction

  vector_t directed[$];

  initial begin
    int p, n, gap, quiet;
    int mr, mc;
    bit fill, drain;
    vector_t x;
    logic signed [31:0] shape_dflt [0:7];
    int shape_rows [0:7];
    int shape_cols [0:7];

    for (int i = 0; i <= 64; i++) row_start[i] = 9'd1;
    term_total = '0;
    dflt = '0;
    n_rows = '0;
    n_cols = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // no rows or columns configured after reset
    send_request(vec(0, 1, 1, 0, 1, 0, 0, ST_RANGE), 0);
    set_shape(32'd0, 7'd64, 7'd64);

    directed.push_back(vec(1, 1, 1, 32'h7fffffff, 1, 32'h7fffffff, 1, ST_DONE));
    directed.push_back(vec(1, 64, 64, 32'h80000000, 1, 32'h80000000, 2, ST_DONE));
    directed.push_back(vec(0, 64, 64, 0, 1, 32'h80000000, 2, ST_DONE));
    directed.push_back(vec(0, 0, 5, 0, 1, 0, 2, ST_RANGE));
    directed.push_back(vec(0, 3, 0, 0, 1, 0, 2, ST_RANGE));
    directed.push_back(vec(1, 65, 1, 9, 1, 0, 2, ST_RANGE));
    directed.push_back(vec(1, 1, 127, 1, 1, 0, 2, ST_RANGE));
    directed.push_back(vec(0, 127, 127, 32'hffffffff, 1, 0, 2, ST_RANGE));
    directed.push_back(vec(1, 10, 10, 0, 1, 0, 2, ST_DONE));
    directed.push_back(vec(1, 1, 2, 5, 0, 0, 0, ST_DONE));
    directed.push_back(vec(1, 1, 1, -1, 0, 0, 0, ST_DONE));
    directed.push_back(vec(1, 1, 2, 0, 1, 0, 2, ST_DONE));
    directed.push_back(vec(0, 1, 2, 0, 1, 0, 2, ST_DONE));
    directed.push_back(vec(1, 64, 1, 123, 0, 0, 0, ST_DONE));
    directed.push_back(vec(1, 32, 33, 32'h55555555, 0, 0, 0, ST_DONE));
    directed.push_back(vec(0, 1, 1, 0, 0, 0, 0, ST_DONE));
    foreach (directed[i]) send_request(directed[i], i % 3);

    shape_dflt = '{32'd0, 32'd0, 32'h80000000, 32'h7fffffff, 32'd0, 32'd0, 32'd5, 32'd0};
    shape_rows = '{64, 64, 8, 64, 1, 0, 16, 64};
    shape_cols = '{64, 64, 8, 1, 64, 0, 16, 64};
    shape_dflt[4] = $urandom;

    for (p = 0; p < 8; p++) begin
      set_shape(shape_dflt[p], 7'(shape_rows[p]), 7'(shape_cols[p]));
      fill = (p == 0);
      drain = (p == 7);
      mr = (shape_rows[p] > 0) ? shape_rows[p] : 1;
      mc = (shape_cols[p] > 0) ? shape_cols[p] : 1;
      quiet = 0;
      for (n = 0; n < ((p == 5) ? 60 : 220); n++) begin
        if (n % 40 == 0) quiet = $urandom_range(0, 1);
        x.typed = 1'b0;
        x.outcome = '0;
        x.mode = fill ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
        x.row = ($urandom_range(0, 9) != 0) ? 7'($urandom_range(1, mr))
                                            : 7'($urandom_range(0, 127));
        x.col = ($urandom_range(0, 9) != 0) ? 7'($urandom_range(1, mc))
                                            : 7'($urandom_range(0, 127));
        case ($urandom_range(0, 9))
          0, 1, 2: x.value = (fill ? dflt + 1 : dflt);
          3:       x.value = 32'h80000000;
          4:       x.value = 32'h7fffffff;
          default: x.value = $urandom;
        endcase
        if (drain && $urandom_range(0, 4) != 0) begin
          x.mode = 1'b1;
          x.value = dflt;
        end
        gap = quiet ? 0 : $urandom_range(0, 18);
        send_request(x, gap);
      end
      // keep stored terms while the default changes under them
      if (p == 1) write_reg(REG_DEFAULT, 32'h7fffffff);
    end

    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("sparse_matrix_csr_store_core verification clean");
    end else begin
      $display("sparse_matrix_csr_store_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/smcsr_pkg.sv
design/sparse_matrix_csr_store_core.sv
tb/sparse_matrix_csr_store_core_test.sv
